### rtl/klp_pkg.sv
`timescale 1ns / 1ps
package klp_pkg;

  localparam int NUM_ANIMS = 4;
  localparam int MAX_KEYS  = 16;

  localparam int ANIM_W = $clog2(NUM_ANIMS);
  localparam int KEY_W  = $clog2(MAX_KEYS);
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int ADDR_W = $clog2(NUM_ANIMS * MAX_KEYS);

  // quotient of the key fraction, 0..65536
  localparam int DIV_QW = 17;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_SET_COUNT = 2'd1,
    OP_EVAL      = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_PIVOT_X = 2'd0,
    REG_PIVOT_Y = 2'd1,
    REG_PIVOT_Z = 2'd2
  } reg_index_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [1:0]         anim_index;
    logic [4:0]         key_slot;
    logic [31:0]        time_value;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] parent_x;
    logic signed [31:0] parent_y;
    logic signed [31:0] parent_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] out_rot_x;
    logic signed [15:0] out_rot_y;
    logic signed [15:0] out_rot_z;
    logic               in_range;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

  // z = 4*q for the quarter wave, mirrored in odd quadrants
  function automatic logic [16:0] sine_z(input logic [15:0] a);
    logic [16:0] m;
    m = a[14] ? (17'd16384 - {3'b000, a[13:0]}) : {3'b000, a[13:0]};
    return {m[14:0], 2'b00};
  endfunction

endpackage

### rtl/klp_div.sv
`timescale 1ns / 1ps
module klp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  klp_pkg::div_req_t req,
  output klp_pkg::div_rsp_t rsp
);
  import klp_pkg::*;

  logic [31:0]       rem_r, rem_nxt;
  logic [31:0]       den_r;
  logic              bit_r;
  logic [DIV_QW-1:0] quo_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [32:0]       trial;
  logic              ge;

  // quotient of (num << 16) / den, known to fit DIV_QW bits
  assign trial   = {rem_r, bit_r};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? 32'(trial - {1'b0, den_r}) : trial[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      rem_r  <= {1'b0, req.num[31:1]};
      bit_r  <= req.num[0];
      den_r  <= req.den;
      quo_r  <= '0;
      cnt_r  <= 5'(DIV_QW);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      bit_r <= 1'b0;
      quo_r <= {quo_r[DIV_QW-2:0], ge};
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

### rtl/keyframe_limb_pose_top.sv
`timescale 1ns / 1ps
// limb pose from cosine-eased keyframe tables
// input channel in_valid/in_ready/in_data carries one item: a keyframe write,
// a keyframe count, or an evaluate item with sample time and parent pose.
// result channel out_valid/out_ready/out_data gives one result per item;
// write and count items answer all zero.
// the user must write the pivot offset via cfg_we/cfg_index/cfg_data only
// at an edge while idle; the block itself does not enforce it. one item
// at a time: a write or count item goes through S_FIN to the output
// register; an evaluate item searches keyframe pairs in order, and when a
// pair brackets the time it adds the 17-step divider and one more sine.
// a single 35x18 multiplier with a registered product does all the sine,
// rotation and easing arithmetic, stepped by the sequencer.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next item is taken while it waits, but
// that item's result holds in the sequencer until out_ready frees the slot.
// reset (synchronous, rst_n low) clears counts, pivot and valid flags; the
// keyframe memory is not cleared and must be written before it is used.
module keyframe_limb_pose_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  klp_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output klp_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import klp_pkg::*;

  typedef struct packed {
    logic [31:0]        time_val;
    logic signed [15:0] ang_z;
    logic signed [15:0] ang_y;
    logic signed [15:0] ang_x;
  } key_entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SN0, S_SN1, S_SN2, S_SN3, S_SN4, S_SN5,
    S_PV1, S_PV2, S_PV3, S_PV4, S_PV5, S_PV6, S_PV7, S_PV8, S_PV9,
    S_SR0, S_SR1, S_SR2, S_DIV0, S_DIV1,
    S_RS1, S_RS2, S_RR0, S_RR1, S_RR2, S_RR3, S_FIN
  } state_t;

  localparam logic [2:0] SEL_COS_Z = 3'd0;
  localparam logic [2:0] SEL_SIN_Z = 3'd1;
  localparam logic [2:0] SEL_COS_Y = 3'd2;
  localparam logic [2:0] SEL_SIN_Y = 3'd3;
  localparam logic [2:0] SEL_EASE  = 3'd4;

  state_t             state_r;
  in_item_t           item_r;
  logic               eval_r, found_r;
  logic [CNT_W-1:0]   key_counts_r [NUM_ANIMS];
  logic signed [31:0] pivot_x_r, pivot_y_r, pivot_z_r;

  key_entry_t         key_mem [NUM_ANIMS * MAX_KEYS];
  key_entry_t         rdata_r;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [CNT_W-1:0]   rd_idx;

  logic [2:0]         sel_r;
  logic [16:0]        z_r, z2_r;
  logic               neg_r;
  logic signed [17:0] cz_r, sz_r, cy_r, sy_r, s_r;
  logic [16:0]        ratio_r;

  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [52:0] mul_full, p_r;
  logic signed [53:0] acc_r, acc_sub, acc_add;
  logic signed [34:0] x1_r;
  logic [31:0]        x2_r, y1_r, z2p_r;

  logic [CNT_W-1:0]   idx_r;
  logic [31:0]        t1_r, t2_r;
  key_entry_t         a1_r, a2_r;
  logic [15:0]        rot_x_r, rot_y_r, rot_z_r;

  logic               in_acc;
  logic               in_anim_ok, item_anim_ok;
  logic [CNT_W-1:0]   eval_cnt;
  logic [15:0]        sin_ang;
  logic [16:0]        sine_mag;
  logic signed [17:0] sine_val;
  logic [16:0]        sq_r1, sq_r2;
  logic signed [16:0] dk_x, dk_y, dk_z;
  logic               bracket;
  logic               out_free;
  out_item_t          out_r, out_nxt;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_ready     = (state_r == S_IDLE);
  assign in_acc       = in_valid && in_ready;
  assign in_anim_ok   = 32'(in_data.anim_index) < NUM_ANIMS;
  assign item_anim_ok = 32'(item_r.anim_index) < NUM_ANIMS;
  assign eval_cnt     = item_anim_ok ? key_counts_r[item_r.anim_index[ANIM_W-1:0]] : '0;
  assign out_free     = !out_valid || out_ready;

  // keyframe memory
  assign wr_addr = ADDR_W'(32'(in_data.anim_index) * MAX_KEYS
                           + 32'(in_data.key_slot[KEY_W-1:0]));
  assign rd_addr = ADDR_W'(32'(item_r.anim_index) * MAX_KEYS + 32'(rd_idx[KEY_W-1:0]));

  always_comb begin
    unique case (state_r)
      S_SR0:   rd_idx = '0;
      S_SR1:   rd_idx = CNT_W'(1);
      default: rd_idx = idx_r + CNT_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.opcode == OP_WRITE && in_anim_ok &&
        32'(in_data.key_slot) < MAX_KEYS) begin
      key_mem[wr_addr] <= '{time_val: in_data.time_value, ang_z: in_data.angle_z,
                            ang_y: in_data.angle_y, ang_x: in_data.angle_x};
    end
    rdata_r <= key_mem[rd_addr];
  end

  // shared multiplier, product registered
  assign sq_r1 = 17'd42048 - p_r[32:16];
  assign sq_r2 = 17'd102944 - p_r[32:16];
  assign dk_x  = 17'(a2_r.ang_x) - 17'(a1_r.ang_x);
  assign dk_y  = 17'(a2_r.ang_y) - 17'(a1_r.ang_y);
  assign dk_z  = 17'(a2_r.ang_z) - 17'(a1_r.ang_z);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SN1: begin mul_a = 35'(z_r);    mul_b = {1'b0, z_r};         end
      S_SN2: begin mul_a = 35'd4640;    mul_b = {1'b0, p_r[32:16]};  end
      S_SN3: begin mul_a = 35'(sq_r1);  mul_b = {1'b0, z2_r};        end
      S_SN4: begin mul_a = 35'(sq_r2);  mul_b = {1'b0, z_r};         end
      S_PV1: begin mul_a = 35'(pivot_x_r); mul_b = cz_r; end
      S_PV2: begin mul_a = 35'(pivot_y_r); mul_b = sz_r; end
      S_PV3: begin mul_a = 35'(pivot_x_r); mul_b = sz_r; end
      S_PV4: begin mul_a = 35'(pivot_y_r); mul_b = cz_r; end
      S_PV5: begin mul_a = x1_r;           mul_b = cy_r; end
      S_PV6: begin mul_a = 35'(pivot_z_r); mul_b = sy_r; end
      S_PV7: begin mul_a = 35'(pivot_z_r); mul_b = cy_r; end
      S_PV8: begin mul_a = x1_r;           mul_b = sy_r; end
      S_RS1: begin mul_a = 35'(s_r);       mul_b = s_r;  end
      S_RR0: begin mul_a = 35'(dk_x); mul_b = {1'b0, ratio_r}; end
      S_RR1: begin mul_a = 35'(dk_y); mul_b = {1'b0, ratio_r}; end
      S_RR2: begin mul_a = 35'(dk_z); mul_b = {1'b0, ratio_r}; end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign acc_sub  = acc_r - 54'(p_r);
  assign acc_add  = acc_r + 54'(p_r);

  // sine angle and result
  always_comb begin
    unique case (sel_r)
      SEL_COS_Z: sin_ang = 16'(item_r.angle_z) + 16'd16384;
      SEL_SIN_Z: sin_ang = 16'(item_r.angle_z);
      SEL_COS_Y: sin_ang = 16'(item_r.angle_y) + 16'd16384;
      default:   sin_ang = 16'(item_r.angle_y);
    endcase
  end

  assign sine_mag = p_r[32:16];
  assign sine_val = neg_r ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
  assign bracket  = (item_r.time_value >= t1_r) && (item_r.time_value <= rdata_r.time_val);

  assign div_req.start = (state_r == S_DIV0) && (t2_r != t1_r);
  assign div_req.num   = item_r.time_value - t1_r;
  assign div_req.den   = t2_r - t1_r;

  klp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    out_nxt = '0;
    if (eval_r) begin
      out_nxt.pos_x     = item_r.parent_x + $signed(x2_r);
      out_nxt.pos_y     = item_r.parent_y + $signed(y1_r);
      out_nxt.pos_z     = item_r.parent_z + $signed(z2p_r);
      out_nxt.out_rot_x = item_r.angle_x + $signed(rot_x_r);
      out_nxt.out_rot_y = item_r.angle_y + $signed(rot_y_r);
      out_nxt.out_rot_z = item_r.angle_z + $signed(rot_z_r);
      out_nxt.in_range  = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      eval_r    <= 1'b0;
      found_r   <= 1'b0;
      pivot_x_r <= '0;
      pivot_y_r <= '0;
      pivot_z_r <= '0;
      for (int i = 0; i < NUM_ANIMS; i++) key_counts_r[i] <= '0;
    end else begin
      p_r <= mul_full;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PIVOT_X: pivot_x_r <= cfg_data;
          REG_PIVOT_Y: pivot_y_r <= cfg_data;
          REG_PIVOT_Z: pivot_z_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            item_r  <= in_data;
            eval_r  <= 1'b0;
            found_r <= 1'b0;
            sel_r   <= SEL_COS_Z;
            state_r <= S_FIN;
            unique case (in_data.opcode)
              OP_SET_COUNT: begin
                if (in_anim_ok) begin
                  key_counts_r[in_data.anim_index[ANIM_W-1:0]] <=
                    (32'(in_data.key_slot) > MAX_KEYS) ? CNT_W'(MAX_KEYS)
                                                       : CNT_W'(in_data.key_slot);
                end
              end
              OP_EVAL: begin
                eval_r  <= 1'b1;
                state_r <= S_SN0;
              end
              default: ;
            endcase
          end
        end
        S_SN0: begin
          if (sel_r == SEL_EASE) begin
            z_r   <= {div_rsp.quo[16:2], 2'b00};
            neg_r <= 1'b0;
          end else begin
            z_r   <= sine_z(sin_ang);
            neg_r <= sin_ang[15];
          end
          state_r <= S_SN1;
        end
        S_SN1: state_r <= S_SN2;
        S_SN2: begin
          z2_r    <= p_r[32:16];
          state_r <= S_SN3;
        end
        S_SN3: state_r <= S_SN4;
        S_SN4: state_r <= S_SN5;
        S_SN5: begin
          unique case (sel_r)
            SEL_COS_Z: cz_r <= sine_val;
            SEL_SIN_Z: sz_r <= sine_val;
            SEL_COS_Y: cy_r <= sine_val;
            SEL_SIN_Y: sy_r <= sine_val;
            default:   s_r  <= sine_val;
          endcase
          sel_r <= sel_r + 3'd1;
          if (sel_r == SEL_EASE) state_r <= S_RS1;
          else if (sel_r == SEL_SIN_Y) state_r <= S_PV1;
          else state_r <= S_SN0;
        end
        S_PV1: state_r <= S_PV2;
        S_PV2: begin acc_r <= 54'(p_r); state_r <= S_PV3; end
        S_PV3: begin x1_r <= acc_sub[50:16]; state_r <= S_PV4; end
        S_PV4: begin acc_r <= 54'(p_r); state_r <= S_PV5; end
        S_PV5: begin y1_r <= acc_add[47:16]; state_r <= S_PV6; end
        S_PV6: begin acc_r <= 54'(p_r); state_r <= S_PV7; end
        S_PV7: begin x2_r <= acc_add[47:16]; state_r <= S_PV8; end
        S_PV8: begin acc_r <= 54'(p_r); state_r <= S_PV9; end
        S_PV9: begin z2p_r <= acc_sub[47:16]; state_r <= S_SR0; end
        S_SR0: begin
          rot_x_r <= '0;
          rot_y_r <= '0;
          rot_z_r <= '0;
          state_r <= (eval_cnt == '0) ? S_FIN : S_SR1;
        end
        S_SR1: begin
          t1_r  <= rdata_r.time_val;
          a1_r  <= rdata_r;
          idx_r <= CNT_W'(1);
          if (eval_cnt == CNT_W'(1)) begin
            // single key: its own rotations
            rot_x_r <= rdata_r.ang_x;
            rot_y_r <= rdata_r.ang_y;
            rot_z_r <= rdata_r.ang_z;
            state_r <= S_FIN;
          end else begin
            state_r <= S_SR2;
          end
        end
        S_SR2: begin
          if (bracket) begin
            found_r <= 1'b1;
            t2_r    <= rdata_r.time_val;
            a2_r    <= rdata_r;
            state_r <= S_DIV0;
          end else if (idx_r + CNT_W'(1) < eval_cnt) begin
            t1_r  <= rdata_r.time_val;
            a1_r  <= rdata_r;
            idx_r <= idx_r + CNT_W'(1);
          end else begin
            // no pair brackets the time: last key
            rot_x_r <= rdata_r.ang_x;
            rot_y_r <= rdata_r.ang_y;
            rot_z_r <= rdata_r.ang_z;
            state_r <= S_FIN;
          end
        end
        S_DIV0: begin
          if (t2_r == t1_r) begin
            // equal key times ease with ratio zero
            rot_x_r <= a1_r.ang_x;
            rot_y_r <= a1_r.ang_y;
            rot_z_r <= a1_r.ang_z;
            state_r <= S_FIN;
          end else begin
            state_r <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_rsp.done) state_r <= S_SN0;
        end
        S_RS1: state_r <= S_RS2;
        S_RS2: begin ratio_r <= p_r[32:16]; state_r <= S_RR0; end
        S_RR0: state_r <= S_RR1;
        S_RR1: begin
          rot_x_r <= a1_r.ang_x + p_r[31:16];
          state_r <= S_RR2;
        end
        S_RR2: begin
          rot_y_r <= a1_r.ang_y + p_r[31:16];
          state_r <= S_RR3;
        end
        S_RR3: begin
          rot_z_r <= a1_r.ang_z + p_r[31:16];
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_r     <= out_nxt;
            out_valid <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_data = out_r;

endmodule

### rtl/klp_checker.sv
`timescale 1ns / 1ps
module klp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input klp_pkg::out_item_t out_data
);
  import klp_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // a new result appears only as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded while busy");

endmodule

bind keyframe_limb_pose_top klp_checker u_klp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
